// ===== src/s2cd_pkg.sv =====
`default_nettype none
package s2cd_pkg;

    localparam int unsigned BASE_YEAR     = 2000;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;

    localparam int unsigned SECS_W = 32;
    localparam int unsigned DAYS_W = 16;
    localparam int unsigned TOD_W  = 17;
    localparam int unsigned REMH_W = 12;
    localparam int unsigned WKQ_W  = 14;
    localparam int unsigned YEAR_W = 12;
    localparam int unsigned PC_W   = 4;

    // quotient = (x * MUL) >> SHIFT, exact over each operand's full range
    // days: x is seconds >> 7, divisor 675
    localparam int unsigned DAY_PRE    = 7;
    localparam int unsigned DAY_SHIFT  = 35;
    localparam logic [25:0] DAY_MUL    = 26'd50903317;
    localparam int unsigned DPROD_W    = 51;
    // weeks: x is the day count, divisor 7
    localparam int unsigned WEEK_SHIFT = 19;
    localparam logic [16:0] WEEK_MUL   = 17'd74899;
    localparam int unsigned WPROD_W    = 33;
    // hours: x is time of day >> 4, divisor 225
    localparam int unsigned HOUR_PRE   = 4;
    localparam int unsigned HOUR_SHIFT = 21;
    localparam logic [13:0] HOUR_MUL   = 14'd9321;
    localparam int unsigned HPROD_W    = 27;
    // minutes: x is seconds into the hour >> 2, divisor 15
    localparam int unsigned MIN_PRE    = 2;
    localparam int unsigned MIN_SHIFT  = 14;
    localparam logic [10:0] MIN_MUL    = 11'd1093;
    localparam int unsigned MPROD_W    = 21;

    localparam logic [YEAR_W-1:0] YEAR_INIT = YEAR_W'(BASE_YEAR);
    localparam logic [1:0]        Y4_INIT   = 2'(BASE_YEAR % 4);
    localparam logic [6:0]        Y100_INIT = 7'(BASE_YEAR % 100);
    localparam logic [8:0]        Y400_INIT = 9'(BASE_YEAR % 400);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DAY_Q,
        OP_DAY_R,
        OP_HR_Q,
        OP_HR_R,
        OP_MIN_Q,
        OP_PREP_YR,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NOIN,
        C_YEAR,
        C_MON,
        C_OBUSY
    } t_csel;

    typedef struct packed {
        t_op             op;
        t_csel           csel;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic no_in;
        logic year_fit;
        logic mon_fit;
        logic out_busy;
    } t_flags;

    localparam logic [PC_W-1:0] S_IDLE    = PC_W'(0);
    localparam logic [PC_W-1:0] S_DAY_Q   = PC_W'(1);
    localparam logic [PC_W-1:0] S_DAY_R   = PC_W'(2);
    localparam logic [PC_W-1:0] S_HR_Q    = PC_W'(3);
    localparam logic [PC_W-1:0] S_HR_R    = PC_W'(4);
    localparam logic [PC_W-1:0] S_MIN_Q   = PC_W'(5);
    localparam logic [PC_W-1:0] S_PREP_YR = PC_W'(6);
    localparam logic [PC_W-1:0] S_YEAR    = PC_W'(7);
    localparam logic [PC_W-1:0] S_MONTH   = PC_W'(8);
    localparam logic [PC_W-1:0] S_EMIT    = PC_W'(9);
    localparam logic [PC_W-1:0] S_END     = PC_W'(10);

    function automatic t_ctrl microcode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, csel: C_ALWAYS, target: S_IDLE};
        case (pc)
            S_IDLE:    w = '{op: OP_LOAD,    csel: C_NOIN,   target: S_IDLE};
            S_DAY_Q:   w = '{op: OP_DAY_Q,   csel: C_NONE,   target: S_IDLE};
            S_DAY_R:   w = '{op: OP_DAY_R,   csel: C_NONE,   target: S_IDLE};
            S_HR_Q:    w = '{op: OP_HR_Q,    csel: C_NONE,   target: S_IDLE};
            S_HR_R:    w = '{op: OP_HR_R,    csel: C_NONE,   target: S_IDLE};
            S_MIN_Q:   w = '{op: OP_MIN_Q,   csel: C_NONE,   target: S_IDLE};
            S_PREP_YR: w = '{op: OP_PREP_YR, csel: C_NONE,   target: S_IDLE};
            S_YEAR:    w = '{op: OP_YEAR,    csel: C_YEAR,   target: S_YEAR};
            S_MONTH:   w = '{op: OP_MONTH,   csel: C_MON,    target: S_MONTH};
            S_EMIT:    w = '{op: OP_EMIT,    csel: C_OBUSY,  target: S_EMIT};
            S_END:     w = '{op: OP_NOP,     csel: C_ALWAYS, target: S_IDLE};
            default:   w = '{op: OP_NOP,     csel: C_ALWAYS, target: S_IDLE};
        endcase
        return w;
    endfunction

    // m is zero-based
    function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] m);
        logic [4:0] d;
        if (m == 4'd1) begin
            d = 5'd28 + {4'd0, leap};
        end else if (m > 4'd6) begin
            d = m[0] ? 5'd31 : 5'd30;
        end else begin
            d = m[0] ? 5'd30 : 5'd31;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== src/s2cd_if.sv =====
`default_nettype none
interface s2cd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_seconds;

    modport source (output valid, output elapsed_seconds, input ready);
    modport sink (input valid, input elapsed_seconds, output ready);
endinterface

interface s2cd_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    modport source (
        output valid, output year, output month, output day_of_month,
        output hour, output minute, output second, output weekday,
        input ready
    );
    modport sink (
        input valid, input year, input month, input day_of_month,
        input hour, input minute, input second, input weekday,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/s2cd_seq.sv =====
`default_nettype none
module s2cd_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  s2cd_pkg::t_flags     i_flags,
    output s2cd_pkg::t_ctrl      o_ctrl
);

    logic [s2cd_pkg::PC_W-1:0] r_pc;
    logic [s2cd_pkg::PC_W-1:0] n_pc;
    s2cd_pkg::t_ctrl           w_ctrl;
    logic                      w_jump;

    assign w_ctrl = s2cd_pkg::microcode(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.csel)
            s2cd_pkg::C_NONE:   w_jump = 1'b0;
            s2cd_pkg::C_ALWAYS: w_jump = 1'b1;
            s2cd_pkg::C_NOIN:   w_jump = i_flags.no_in;
            s2cd_pkg::C_YEAR:   w_jump = i_flags.year_fit;
            s2cd_pkg::C_MON:    w_jump = i_flags.mon_fit;
            s2cd_pkg::C_OBUSY:  w_jump = i_flags.out_busy;
            default:            w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_ctrl.target : r_pc + s2cd_pkg::PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= s2cd_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

// ===== src/seconds_to_calendar_date.sv =====
// Converts seconds since midnight of 1 January 2000 into year, month, day of month,
// hour, minute, second and weekday, one word at a time. A small microcode table steps
// a plain datapath: the day count, the weeks, the hour and the minute come from
// reciprocal multiplications by constants, each followed by a step that forms the
// remainder, then one year is subtracted per cycle and one month per cycle. A result
// word is ready once the year loop and the month loop have run; the year loop
// dominates. The input is taken only while the sequencer waits at its idle step,
// which it reaches again after the emit and end steps; a finished result sits in an
// output register until it is taken, and the next item waits at its emit step behind
// it. Origin weekday is written through i_cfg_we/i_cfg_wdata and resets to 5
// (Saturday); a value of 7 acts as Monday.
`default_nettype none
module seconds_to_calendar_date (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [2:0]        i_cfg_wdata,
    s2cd_in_if.sink          i_in,
    s2cd_out_if.source       o_out
);

    localparam int unsigned SECS_W     = s2cd_pkg::SECS_W;
    localparam int unsigned DAYS_W     = s2cd_pkg::DAYS_W;
    localparam int unsigned TOD_W      = s2cd_pkg::TOD_W;
    localparam int unsigned REMH_W     = s2cd_pkg::REMH_W;
    localparam int unsigned WKQ_W      = s2cd_pkg::WKQ_W;
    localparam int unsigned DPROD_W    = s2cd_pkg::DPROD_W;
    localparam int unsigned WPROD_W    = s2cd_pkg::WPROD_W;
    localparam int unsigned HPROD_W    = s2cd_pkg::HPROD_W;
    localparam int unsigned MPROD_W    = s2cd_pkg::MPROD_W;
    localparam int unsigned DAY_PRE    = s2cd_pkg::DAY_PRE;
    localparam int unsigned HOUR_PRE   = s2cd_pkg::HOUR_PRE;
    localparam int unsigned MIN_PRE    = s2cd_pkg::MIN_PRE;
    localparam int unsigned DAY_SHIFT  = s2cd_pkg::DAY_SHIFT;
    localparam int unsigned WEEK_SHIFT = s2cd_pkg::WEEK_SHIFT;
    localparam int unsigned HOUR_SHIFT = s2cd_pkg::HOUR_SHIFT;
    localparam int unsigned MIN_SHIFT  = s2cd_pkg::MIN_SHIFT;

    s2cd_pkg::t_ctrl  w_ctrl;
    s2cd_pkg::t_flags w_flags;

    logic [2:0]                    r_origin;
    logic [SECS_W-1:0]             r_secs, n_secs;
    logic [DAYS_W-1:0]             r_dcnt, n_dcnt;
    logic [TOD_W-1:0]              r_tod, n_tod;
    logic [WKQ_W-1:0]              r_wkq, n_wkq;
    logic [2:0]                    r_wdrem, n_wdrem;
    logic [4:0]                    r_hour, n_hour;
    logic [REMH_W-1:0]             r_remh, n_remh;
    logic [5:0]                    r_min, n_min;
    logic [5:0]                    r_sec, n_sec;
    logic [s2cd_pkg::YEAR_W-1:0]   r_year, n_year;
    logic [1:0]                    r_y4, n_y4;
    logic [6:0]                    r_y100, n_y100;
    logic [8:0]                    r_y400, n_y400;
    logic [3:0]                    r_mon, n_mon;

    logic        r_ovalid;
    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_dom;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_min;
    logic [5:0]  r_o_sec;
    logic [2:0]  r_o_wd;

    logic [DPROD_W-1:0] w_dprod;
    logic [SECS_W-1:0]  w_dsecs;
    logic [WPROD_W-1:0] w_wprod;
    logic [DAYS_W-1:0]  w_wdays;
    logic [HPROD_W-1:0] w_hprod;
    logic [TOD_W-1:0]   w_hsecs;
    logic [MPROD_W-1:0] w_mprod;
    logic [REMH_W-1:0]  w_msecs;
    logic               w_leap;
    logic [8:0]         w_ylen;
    logic [4:0]         w_mlen;
    logic [3:0]         w_wdsum;
    logic [2:0]         w_wd;
    logic               w_emit;

    s2cd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign i_in.ready = i_rst_n && (w_ctrl.op == s2cd_pkg::OP_LOAD);

    // quotient and remainder products
    assign w_dprod = DPROD_W'(r_secs[SECS_W-1:DAY_PRE]) * DPROD_W'(s2cd_pkg::DAY_MUL);
    assign w_dsecs = SECS_W'(r_dcnt) * SECS_W'(s2cd_pkg::SECS_PER_DAY);
    assign w_wprod = WPROD_W'(r_dcnt) * WPROD_W'(s2cd_pkg::WEEK_MUL);
    assign w_wdays = DAYS_W'(r_wkq) * DAYS_W'(s2cd_pkg::DAYS_PER_WEEK);
    assign w_hprod = HPROD_W'(r_tod[TOD_W-1:HOUR_PRE]) * HPROD_W'(s2cd_pkg::HOUR_MUL);
    assign w_hsecs = TOD_W'(r_hour) * TOD_W'(s2cd_pkg::SECS_PER_HOUR);
    assign w_mprod = MPROD_W'(r_remh[REMH_W-1:MIN_PRE]) * MPROD_W'(s2cd_pkg::MIN_MUL);
    assign w_msecs = REMH_W'(r_min) * REMH_W'(s2cd_pkg::SECS_PER_MIN);

    assign w_leap  = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign w_ylen  = 9'd365 + {8'd0, w_leap};
    assign w_mlen  = s2cd_pkg::days_in_month(w_leap, r_mon);

    assign w_wdsum = {1'b0, r_wdrem} + {1'b0, r_origin};
    assign w_wd    = (w_wdsum >= 4'd7) ? 3'(w_wdsum - 4'd7) : w_wdsum[2:0];

    assign w_flags.no_in    = !i_in.valid;
    assign w_flags.year_fit = (r_dcnt >= {7'd0, w_ylen});
    assign w_flags.mon_fit  = (r_mon < 4'd11) && (r_dcnt >= {11'd0, w_mlen});
    assign w_flags.out_busy = r_ovalid && !o_out.ready;

    assign w_emit = (w_ctrl.op == s2cd_pkg::OP_EMIT) && !w_flags.out_busy;

    always_comb begin
        n_secs  = r_secs;
        n_dcnt  = r_dcnt;
        n_tod   = r_tod;
        n_wkq   = r_wkq;
        n_wdrem = r_wdrem;
        n_hour  = r_hour;
        n_remh  = r_remh;
        n_min   = r_min;
        n_sec   = r_sec;
        n_year  = r_year;
        n_y4    = r_y4;
        n_y100  = r_y100;
        n_y400  = r_y400;
        n_mon   = r_mon;
        case (w_ctrl.op)
            s2cd_pkg::OP_LOAD: begin
                n_secs = i_in.elapsed_seconds;
            end
            s2cd_pkg::OP_DAY_Q: begin
                n_dcnt = w_dprod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
            end
            s2cd_pkg::OP_DAY_R: begin
                n_tod = TOD_W'(r_secs - w_dsecs);
                n_wkq = w_wprod[WEEK_SHIFT+WKQ_W-1:WEEK_SHIFT];
            end
            s2cd_pkg::OP_HR_Q: begin
                n_wdrem = 3'(r_dcnt - w_wdays);
                n_hour  = w_hprod[HOUR_SHIFT+4:HOUR_SHIFT];
            end
            s2cd_pkg::OP_HR_R: begin
                n_remh = REMH_W'(r_tod - w_hsecs);
            end
            s2cd_pkg::OP_MIN_Q: begin
                n_min = w_mprod[MIN_SHIFT+5:MIN_SHIFT];
            end
            s2cd_pkg::OP_PREP_YR: begin
                n_sec  = 6'(r_remh - w_msecs);
                n_year = s2cd_pkg::YEAR_INIT;
                n_y4   = s2cd_pkg::Y4_INIT;
                n_y100 = s2cd_pkg::Y100_INIT;
                n_y400 = s2cd_pkg::Y400_INIT;
                n_mon  = '0;
            end
            s2cd_pkg::OP_YEAR: begin
                if (w_flags.year_fit) begin
                    n_dcnt = r_dcnt - {7'd0, w_ylen};
                    n_year = r_year + 12'd1;
                    n_y4   = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            s2cd_pkg::OP_MONTH: begin
                if (w_flags.mon_fit) begin
                    n_dcnt = r_dcnt - {11'd0, w_mlen};
                    n_mon  = r_mon + 4'd1;
                end
            end
            s2cd_pkg::OP_EMIT: begin
            end
            s2cd_pkg::OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_secs  <= n_secs;
        r_dcnt  <= n_dcnt;
        r_tod   <= n_tod;
        r_wkq   <= n_wkq;
        r_wdrem <= n_wdrem;
        r_hour  <= n_hour;
        r_remh  <= n_remh;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_year  <= n_year;
        r_y4    <= n_y4;
        r_y100  <= n_y100;
        r_y400  <= n_y400;
        r_mon   <= n_mon;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= 3'd5;
        end else if (i_cfg_we) begin
            r_origin <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_year  <= r_year;
            r_o_month <= r_mon + 4'd1;
            r_o_dom   <= r_dcnt[4:0] + 5'd1;
            r_o_hour  <= r_hour;
            r_o_min   <= r_min;
            r_o_sec   <= r_sec;
            r_o_wd    <= w_wd;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.year         = r_o_year;
    assign o_out.month        = r_o_month;
    assign o_out.day_of_month = r_o_dom;
    assign o_out.hour         = r_o_hour;
    assign o_out.minute       = r_o_min;
    assign o_out.second       = r_o_sec;
    assign o_out.weekday      = r_o_wd;

endmodule
`default_nettype wire
